>>> design/qas_pkg.sv
// shared types and character codes for the quoted argument splitter
`default_nettype none

package qas_pkg;

  // character codes
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChNl        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChVtab      = 8'h0B;
  localparam logic [7:0] ChFormfeed  = 8'h0C;

  // field widths of one result transaction
  localparam int unsigned CharW  = 8;
  localparam int unsigned TokPosW = 11;
  localparam int unsigned TokCntW = 8;

  // one result transaction
  typedef struct packed {
    logic               line_end;
    logic [TokCntW-1:0] token_count;
    logic [TokPosW-1:0] token_position;
    logic               token_start;
    logic [CharW-1:0]   char_out;
  } qas_result_t;

endpackage

`default_nettype wire

>>> design/qas_in_stage.sv
// input register stage holding one accepted byte
`default_nettype none

module qas_in_stage
  import qas_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CharW-1:0] in_data_i,
  input  wire logic             advance_i,
  output logic                  held_valid_o,
  output logic [CharW-1:0]      held_data_o
);

  logic             valid_q, valid_d;
  logic [CharW-1:0] data_q;

  // free when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_data_o  = data_q;

endmodule

`default_nettype wire

>>> design/qas_parse.sv
// quote, escape and token state with the per-byte classification
`default_nettype none

module qas_parse
  import qas_pkg::*;
#(
  parameter int unsigned MAX_TOKENS  = 255,
  parameter int unsigned LINE_LENGTH = 2048
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [CharW-1:0] char_i,
  output qas_result_t           result_o
);

  localparam int unsigned CntW = $clog2(MAX_TOKENS + 1);
  localparam int unsigned PosW = $clog2(LINE_LENGTH);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TOKENS);
  localparam logic [PosW-1:0] PosMax = PosW'(LINE_LENGTH - 1);

  logic            squote_q, squote_d;
  logic            dquote_q, dquote_d;
  logic            escape_q, escape_d;
  logic            token_q,  token_d;
  logic [CntW-1:0] cnt_q,    cnt_d;
  logic [PosW-1:0] pos_q,    pos_d;

  logic             is_eol;
  logic             is_blank;
  logic             start;
  logic [CharW-1:0] ch;

  assign is_eol   = (char_i == ChNl) || (char_i == ChCr) || (char_i == ChNul);
  assign is_blank = (char_i == ChSpace) || (char_i == ChTab) ||
                    (char_i == ChVtab) || (char_i == ChFormfeed);

  // next state and reported byte
  always_comb begin
    squote_d = squote_q;
    dquote_d = dquote_q;
    escape_d = escape_q;
    token_d  = token_q;
    cnt_d    = cnt_q;
    pos_d    = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;
    start    = 1'b0;
    ch       = char_i;
    priority if (is_eol) begin
      squote_d = 1'b0;
      dquote_d = 1'b0;
      escape_d = 1'b0;
      token_d  = 1'b0;
      cnt_d    = '0;
      pos_d    = '0;
      ch       = '0;
    end else if (char_i == ChBackslash) begin
      escape_d = !escape_q;
    end else if (char_i == ChSquote) begin
      if (!dquote_q && !escape_q) begin
        squote_d = !squote_q;
        ch       = '0;
        token_d  = 1'b0;
      end
    end else if (char_i == ChDquote) begin
      if (!squote_q && !escape_q) begin
        dquote_d = !dquote_q;
        ch       = '0;
        token_d  = 1'b0;
      end
    end else begin
      if (is_blank && !escape_q && !squote_q && !dquote_q) begin
        ch      = '0;
        token_d = 1'b0;
      end else if (!token_q) begin
        start   = 1'b1;
        token_d = 1'b1;
        if (cnt_q < CntMax) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      escape_d = 1'b0;
    end
  end

  // state registers, updated once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      squote_q <= 1'b0;
      dquote_q <= 1'b0;
      escape_q <= 1'b0;
      token_q  <= 1'b0;
      cnt_q    <= '0;
      pos_q    <= '0;
    end else if (step_i) begin
      squote_q <= squote_d;
      dquote_q <= dquote_d;
      escape_q <= escape_d;
      token_q  <= token_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
    end
  end

  // count reported before the line clears, after any increment otherwise
  always_comb begin
    result_o.char_out       = ch;
    result_o.token_start    = start;
    result_o.token_position = TokPosW'(pos_q);
    result_o.token_count    = is_eol ? TokCntW'(cnt_q) : TokCntW'(cnt_d);
    result_o.line_end       = is_eol;
  end

endmodule

`default_nettype wire

>>> design/qas_out_stage.sv
// result register facing the output stream
`default_nettype none

module qas_out_stage
  import qas_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        held_valid_i,
  input  qas_result_t      result_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output qas_result_t      out_result_o
);

  logic        valid_q, valid_d;
  qas_result_t result_q;

  // move a byte on when the register is empty or being drained
  assign advance_o = held_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

`default_nettype wire

>>> design/quoted_argument_splitter_core.sv
// top level of the quoted argument splitter
//
// Splits a text line, one byte per transaction, into shell style
// arguments with single quotes, double quotes and backslash escapes.
// Input stream s_axis: one byte per transaction in s_axis_tdata.
// Output stream m_axis: one result per input byte; tdata carries the
// byte (zero where it became a terminator), the token start mark, the
// byte offset in the line and the running argument count; tlast marks
// the byte that ended the line (newline, carriage return or NUL).
// Each byte passes through the input register, then the parse logic and
// the result register, and its result is offered on m_axis from there.
// Throughput: one byte per cycle while m_axis_tready stays high; the quote,
// escape and token flags are updated between the two registers.
// When the receiver stalls the result register holds its transaction,
// the input register still takes one more byte if empty, and then
// s_axis_tready drops until the result register drains.
// Reset clears all flags, the count and the position and empties both
// registers.
`default_nettype none

module quoted_argument_splitter_core
  import qas_pkg::*;
#(
  parameter int unsigned MAX_TOKENS  = 255,
  parameter int unsigned LINE_LENGTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] char_out, [8] token_start,
                                           // [19:9] token_position,
                                           // [27:20] token_count, [31:28] zero
  output logic             m_axis_tlast    // line_end
);

  logic             held_valid;
  logic [CharW-1:0] held_data;
  logic             advance;
  qas_result_t      result;
  qas_result_t      out_result;

  // input register
  qas_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_data_o  (held_data)
  );

  // per-byte state update
  qas_parse #(
    .MAX_TOKENS  (MAX_TOKENS),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .char_i   (held_data),
    .result_o (result)
  );

  // result register
  qas_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .held_valid_i (held_valid),
    .result_i     (result),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (out_result)
  );

  // pack the output transaction
  assign m_axis_tdata = {4'b0000, out_result.token_count, out_result.token_position,
                         out_result.token_start, out_result.char_out};
  assign m_axis_tlast = out_result.line_end;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the quoted argument splitter core
module testbench;
  import qas_pkg::*;

  localparam int unsigned Period     = 12;
  localparam int unsigned MaxTokens  = 255;
  localparam int unsigned LineLength = 2048;
  localparam int unsigned RunCycles  = 300_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [7:0] char_out, [8] token_start,
                                     // [19:9] token_position,
                                     // [27:20] token_count, [31:28] zero
  logic        m_axis_tlast;

  // tokeniser state as this line has left it
  logic        in_squote;
  logic        in_dquote;
  logic        escaped;
  logic        in_arg;
  int unsigned arg_total;
  int unsigned char_offset;

  qas_result_t token_results_q[$];
  int unsigned mismatch_count;

  // idling controls shared by the tests
  bit          src_eager;
  bit          snk_eager;
  int unsigned sink_hold_cycles;

  quoted_argument_splitter_core #(
    .MAX_TOKENS (MaxTokens),
    .LINE_LENGTH(LineLength)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #(Period / 2) clk_i = 1'b1;
    #(Period / 2) clk_i = 1'b0;
  end

  initial begin
    in_squote        = 1'b0;
    in_dquote        = 1'b0;
    escaped          = 1'b0;
    in_arg           = 1'b0;
    arg_total        = 0;
    char_offset      = 0;
    mismatch_count   = 0;
    src_eager        = 1'b0;
    snk_eager        = 1'b0;
    sink_hold_cycles = 0;
  end

  // work out the result of one accepted byte and advance the state
  function automatic void tokenise_char(input logic [7:0] c);
    qas_result_t res;
    logic        blank;
    res                = '0;
    res.char_out       = c;
    res.token_position = TokPosW'(char_offset);
    blank = (c == ChSpace) || (c == ChTab) || (c == ChVtab) || (c == ChFormfeed);
    if (c == ChNl || c == ChCr || c == ChNul) begin
      // line end clears everything
      res.char_out    = '0;
      res.token_count = TokCntW'(arg_total);
      res.line_end    = 1'b1;
      in_squote       = 1'b0;
      in_dquote       = 1'b0;
      escaped         = 1'b0;
      in_arg          = 1'b0;
      arg_total       = 0;
      char_offset     = 0;
      token_results_q.push_back(res);
      return;
    end
    if (c == ChBackslash) begin
      escaped = !escaped;
    end else if (c == ChSquote) begin
      if (!in_dquote && !escaped) begin
        in_squote    = !in_squote;
        res.char_out = '0;
        in_arg       = 1'b0;
      end
    end else if (c == ChDquote) begin
      if (!in_squote && !escaped) begin
        in_dquote    = !in_dquote;
        res.char_out = '0;
        in_arg       = 1'b0;
      end
    end else begin
      if (blank && !escaped && !in_squote && !in_dquote) begin
        res.char_out = '0;
        in_arg       = 1'b0;
      end else if (!in_arg) begin
        res.token_start = 1'b1;
        if (arg_total < MaxTokens) arg_total++;
        in_arg = 1'b1;
      end
      escaped = 1'b0;
    end
    if (char_offset < LineLength - 1) char_offset++;
    res.token_count = TokCntW'(arg_total);
    token_results_q.push_back(res);
  endfunction

  // offer one byte and wait for the transaction to complete
  task automatic offer_char(input logic [7:0] c);
    int unsigned gap;
    gap = src_eager ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    tokenise_char(c);
  endtask

  task automatic note_mismatch(input string what, input qas_result_t want,
                               input qas_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: want char %h start %b pos %0d count %0d end %b", $realtime, what,
               want.char_out, want.token_start, want.token_position, want.token_count,
               want.line_end);
      $display("%0t %s: got  char %h start %b pos %0d count %0d end %b pad %h", $realtime,
               what, got.char_out, got.token_start, got.token_position, got.token_count,
               got.line_end, m_axis_tdata[31:28]);
    end
  endtask

  // receiver side: random stalls and the occasional long hold
  initial begin : drain_results
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        while (sink_hold_cycles != 0) begin
          @(posedge clk_i);
          sink_hold_cycles--;
        end
      end
      gap = snk_eager ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    qas_result_t got;
    qas_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = qas_result_t'({m_axis_tlast, m_axis_tdata[27:0]});
      if (token_results_q.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = token_results_q.pop_front();
        if (got.char_out !== want.char_out || got.token_start !== want.token_start
            || got.token_position !== want.token_position
            || got.token_count !== want.token_count || got.line_end !== want.line_end
            || m_axis_tdata[31:28] !== 4'b0000) begin
          note_mismatch("field mismatch", want, got);
        end
      end
    end
  end

  // extremes, every byte class, quoting and escape corners, all line ends
  task automatic test_directed_chars();
    logic [7:0] seq[$];
    seq = '{8'h61, 8'h62, ChSpace, ChTab, ChVtab, ChFormfeed, 8'h63, ChNl,
            ChSquote, 8'h78, ChSpace, ChDquote, ChSquote,
            ChDquote, ChSquote, ChDquote,
            ChBackslash, ChSquote, ChBackslash, ChBackslash, ChSpace,
            8'hFF, ChCr, 8'h80, ChNul};
    src_eager = 1'b0;
    snk_eager = 1'b0;
    foreach (seq[i]) offer_char(seq[i]);
  endtask

  // one line with enough arguments to saturate the count
  task automatic test_long_line();
    src_eager = 1'b1;
    snk_eager = 1'b1;
    for (int i = 0; i < 300; i++) begin
      offer_char(8'h41 + 8'($urandom_range(0, 25)));
      offer_char(($urandom_range(0, 1) == 0) ? ChSpace : ChTab);
    end
    offer_char(ChNl);
  endtask

  // receiver holds off while bytes keep coming, so the input stalls
  task automatic test_receiver_hold();
    src_eager        = 1'b1;
    snk_eager        = 1'b0;
    sink_hold_cycles = 60;
    for (int i = 0; i < 40; i++) offer_char(8'h61 + 8'($urandom_range(0, 25)));
    offer_char(ChCr);
  endtask

  // mostly well formed lines with random content, some raw noise
  task automatic test_random_lines(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    bit          noisy;
    logic [7:0]  c;
    sent = 0;
    while (sent < n_items) begin
      src_eager = ($urandom_range(0, 3) == 0);
      snk_eager = ($urandom_range(0, 3) == 0);
      noisy     = ($urandom_range(0, 6) == 0);
      len       = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(0, 99);
        if (noisy) c = 8'($urandom_range(0, 255));
        else if (roll < 50) c = 8'h21 + 8'($urandom_range(0, 93));
        else if (roll < 62) begin
          case ($urandom_range(0, 3))
            0:       c = ChSpace;
            1:       c = ChTab;
            2:       c = ChVtab;
            default: c = ChFormfeed;
          endcase
        end
        else if (roll < 74) c = ChSquote;
        else if (roll < 86) c = ChDquote;
        else c = ChBackslash;
        offer_char(c);
      end
      case ($urandom_range(0, 2))
        0:       offer_char(ChNl);
        1:       offer_char(ChCr);
        default: offer_char(ChNul);
      endcase
      sent += len + 1;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_chars();
    test_receiver_hold();
    test_long_line();
    test_random_lines(580);
    s_axis_tvalid <= 1'b0;
    while (token_results_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(Period * RunCycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
